// File: rtl/core/tsu_pkg.sv
package tsu_pkg;

    // Sine table size and derived phase widths.
    localparam int TAB_BITS = 10;
    localparam int TAB_N    = 1 << TAB_BITS;
    localparam int PH_BITS  = TAB_BITS + 2;
    localparam int QB       = TAB_BITS + 3;

    // Field widths.
    localparam int LEN_W     = 16;
    localparam int N_W       = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // Fixed-point constants: pi/2 in Q30 and 1/(4*pi) in Q32.
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [28:0] INV_4PI_Q32 = 29'd341782638;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_ACCEL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_JERK      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_VELOCITY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_VELOCITY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LENGTH = 3'd4;

    // Which branch of the profile a sample falls in.
    typedef enum logic [1:0] {
        KIND_START,
        KIND_END,
        KIND_MID
    } kind_t;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic signed [31:0] accel;
        logic signed [31:0] jerk;
        logic signed [31:0] v0;
        logic signed [31:0] vend;
        logic [LEN_W-1:0]   len;
    } cfg_t;

    typedef logic [30:0] sin_tab_t [0:TAB_N];

    // Quarter-wave sine in Q30, built from an eight-term series at elaboration.
    function automatic sin_tab_t build_sin_tab();
        sin_tab_t    tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        for (int k = 0; k <= TAB_N; k++) begin
            x    = (64'(HALF_PI_Q30) * 64'(k) + 64'(TAB_N / 2)) >> TAB_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd210;
            sum  = sum - longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > (longint'(1) << 30)) begin
                sum = longint'(1) << 30;
            end
            tab[k] = 31'(sum);
        end
        return tab;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

    // Divide by 2^sh, rounding to nearest with halves away from zero.
    function automatic logic signed [65:0] round_shift(input logic signed [65:0] v,
                                                       input int sh);
        logic [65:0] mag;
        logic [65:0] r;
        mag = v[65] ? 66'(-v) : 66'(v);
        r   = (mag + (66'd1 << (sh - 1))) >> sh;
        return v[65] ? -$signed(r) : $signed(r);
    endfunction

endpackage

// File: rtl/core/tsu_div.sv
module tsu_div
    import tsu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [N_W-1:0]     n,
    input  logic [LEN_W-1:0]   len,
    output logic               out_valid,
    output logic [PH_BITS-1:0] phase
);

    localparam int DR_W = LEN_W + 1;

    logic [DR_W-1:0]     rem_reg [0:QB];
    logic [DR_W-1:0]     rem_next [1:QB];
    logic [QB-1:0]       quo_reg [0:QB];
    logic [QB-1:0]       quo_next [1:QB];
    logic [DR_W:0]       trial [0:QB-1];
    logic [QB:0]         valid_reg;
    logic [LEN_W+QB-1:0] len_x;
    logic [DR_W:0]       divisor;

    // The dividend is n*2^QB + len; its low bits are the low bits of len.
    assign len_x   = (LEN_W + QB)'(len);
    assign divisor = (DR_W + 1)'({len, 1'b0});

    // One restoring step per stage, one quotient bit each.
    always_comb
    begin
        for (int k = 0; k < QB; k++)
        begin
            trial[k] = {rem_reg[k], len_x[QB-1-k]};
            if (trial[k] >= divisor)
            begin
                rem_next[k+1] = DR_W'(trial[k] - divisor);
                quo_next[k+1] = {quo_reg[k][QB-2:0], 1'b1};
            end
            else
            begin
                rem_next[k+1] = DR_W'(trial[k]);
                quo_next[k+1] = {quo_reg[k][QB-2:0], 1'b0};
            end
        end
    end

    // Valid bits travel with the partial remainders.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[QB-1:0], in_valid};
        end
    end

    // Stage registers for remainder and quotient.
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= DR_W'({1'b0, n}) + DR_W'(len_x >> QB);
        quo_reg[0] <= '0;
        for (int k = 1; k <= QB; k++)
        begin
            rem_reg[k] <= rem_next[k];
            quo_reg[k] <= quo_next[k];
        end
    end

    assign out_valid = valid_reg[QB];
    assign phase     = quo_reg[QB][PH_BITS-1:0];

endmodule

// File: rtl/core/tsu_sine_lut.sv
module tsu_sine_lut
    import tsu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [PH_BITS-1:0] phase,
    output logic               out_valid,
    output logic signed [31:0] sin_val,
    output logic signed [31:0] cos_val
);

    logic [TAB_BITS-1:0] off;
    logic [TAB_BITS:0]   off_mirror;
    logic [30:0]         t0_reg;
    logic [30:0]         t1_reg;
    logic [1:0]          quad_reg;
    logic [1:0]          valid_reg;
    logic signed [31:0]  s_mag;
    logic signed [31:0]  c_mag;
    logic signed [31:0]  sin_reg;
    logic signed [31:0]  cos_reg;

    assign off        = phase[TAB_BITS-1:0];
    assign off_mirror = (TAB_BITS + 1)'(TAB_N) - {1'b0, off};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    // Read the table at the offset and at its mirror.
    always_ff @(posedge clk)
    begin
        t0_reg   <= SIN_TAB[off];
        t1_reg   <= SIN_TAB[off_mirror];
        quad_reg <= phase[PH_BITS-1:TAB_BITS];
    end

    // Odd quadrants swap sine and cosine; signs follow the quadrant.
    always_comb
    begin
        s_mag = $signed(32'(quad_reg[0] ? t1_reg : t0_reg));
        c_mag = $signed(32'(quad_reg[0] ? t0_reg : t1_reg));
    end

    always_ff @(posedge clk)
    begin
        sin_reg <= quad_reg[1] ? -s_mag : s_mag;
        cos_reg <= (quad_reg[1] ^ quad_reg[0]) ? -c_mag : c_mag;
    end

    assign out_valid = valid_reg[1];
    assign sin_val   = sin_reg;
    assign cos_val   = cos_reg;

endmodule

// File: rtl/core/tsu_kin.sv
module tsu_kin
    import tsu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    input  logic signed [31:0] sin_val,
    input  logic signed [31:0] cos_val,
    input  logic [N_W-1:0]     n,
    input  kind_t              kind,
    output logic               out_valid,
    output logic signed [31:0] jerk,
    output logic signed [31:0] accel,
    output logic signed [31:0] velocity,
    output logic signed [47:0] distance,
    output logic               saturated
);

    localparam logic signed [32:0] Q30_ONE = 33'sd1073741824;

    logic [6:0]         valid_reg;
    kind_t              kind_reg [0:5];
    logic signed [32:0] u_val;

    logic signed [63:0] js1_reg;
    logic signed [64:0] au1_reg;
    logic signed [63:0] as1_reg;
    logic signed [48:0] an1_reg;
    logic signed [48:0] v0n1_reg;
    logic [31:0]        nn1_reg;
    logic [44:0]        kvp1_reg;

    logic signed [33:0] jerk2_reg;
    logic signed [31:0] acc2_reg;
    logic signed [33:0] q2_reg;
    logic signed [33:0] p2_reg;
    logic signed [48:0] an2_reg;
    logic [28:0]        kv2_reg;
    logic signed [64:0] ann2_reg;
    logic signed [48:0] v0n2_reg;

    logic signed [63:0] pk3_reg;
    logic [57:0]        kvsq3_reg;
    logic signed [63:0] ann3_reg;
    logic signed [33:0] jerk3_reg;
    logic signed [31:0] acc3_reg;
    logic signed [33:0] q3_reg;
    logic signed [48:0] an3_reg;
    logic signed [48:0] v0n3_reg;

    logic [42:0]        kd4_reg;
    logic signed [49:0] vel4_reg;
    logic signed [33:0] jerk4_reg;
    logic signed [31:0] acc4_reg;
    logic signed [33:0] q4_reg;
    logic signed [63:0] ann4_reg;
    logic signed [48:0] v0n4_reg;

    logic signed [61:0] qhi5_reg;
    logic signed [50:0] qlo5_reg;
    logic signed [33:0] jerk5_reg;
    logic signed [31:0] acc5_reg;
    logic signed [49:0] vel5_reg;
    logic signed [63:0] ann5_reg;
    logic signed [48:0] v0n5_reg;

    logic signed [65:0] dist6_reg;
    logic signed [33:0] jerk6_reg;
    logic signed [31:0] acc6_reg;
    logic signed [49:0] vel6_reg;

    logic signed [31:0] jerk_clip;
    logic signed [31:0] vel_clip;
    logic signed [47:0] dist_clip;
    logic               sat_any;
    logic signed [31:0] jerk_next;
    logic signed [31:0] accel_next;
    logic signed [31:0] velocity_next;
    logic signed [47:0] distance_next;
    logic               saturated_next;
    logic signed [31:0] jerk_reg;
    logic signed [31:0] accel_reg;
    logic signed [31:0] velocity_reg;
    logic signed [47:0] distance_reg;
    logic               saturated_reg;

    // Valid bits for the seven stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[5:0], in_valid};
        end
    end

    assign u_val = Q30_ONE - 33'(cos_val);

    // Stage 1: first products.
    always_ff @(posedge clk)
    begin
        kind_reg[0] <= kind;
        js1_reg     <= cfg.jerk * sin_val;
        au1_reg     <= cfg.accel * u_val;
        as1_reg     <= cfg.accel * sin_val;
        an1_reg     <= cfg.accel * $signed({1'b0, n});
        v0n1_reg    <= cfg.v0 * $signed({1'b0, n});
        nn1_reg     <= n * n;
        kvp1_reg    <= cfg.len * INV_4PI_Q32;
    end

    // Stage 2: rounding of the first products, A*n*n, velocity scale.
    always_ff @(posedge clk)
    begin
        kind_reg[1] <= kind_reg[0];
        jerk2_reg   <= 34'(round_shift(66'(js1_reg), 30));
        acc2_reg    <= 32'(round_shift(66'(au1_reg), 31));
        q2_reg      <= 34'(round_shift(66'(au1_reg), 30));
        p2_reg      <= 34'(round_shift(66'(as1_reg), 30));
        an2_reg     <= 49'(round_shift(66'(an1_reg), 1));
        kv2_reg     <= 29'((kvp1_reg + 45'd32768) >> 16);
        ann2_reg    <= cfg.accel * $signed({1'b0, nn1_reg});
        v0n2_reg    <= v0n1_reg;
    end

    // Stage 3: sine term of velocity and the square of the scale.
    always_ff @(posedge clk)
    begin
        kind_reg[2] <= kind_reg[1];
        pk3_reg     <= p2_reg * $signed({1'b0, kv2_reg});
        kvsq3_reg   <= kv2_reg * kv2_reg;
        ann3_reg    <= 64'(round_shift(66'(ann2_reg), 2));
        jerk3_reg   <= jerk2_reg;
        acc3_reg    <= acc2_reg;
        q3_reg      <= q2_reg;
        an3_reg     <= an2_reg;
        v0n3_reg    <= v0n2_reg;
    end

    // Stage 4: velocity sum and distance scale.
    always_ff @(posedge clk)
    begin
        kind_reg[3] <= kind_reg[2];
        kd4_reg     <= 43'((kvsq3_reg + 58'd16384) >> 15);
        vel4_reg    <= 50'(an3_reg) + 50'(cfg.v0)
                     - 50'(round_shift(66'(pk3_reg), 16));
        jerk4_reg   <= jerk3_reg;
        acc4_reg    <= acc3_reg;
        q4_reg      <= q3_reg;
        ann4_reg    <= ann3_reg;
        v0n4_reg    <= v0n3_reg;
    end

    // Stage 5: cosine term of distance in high and low halves.
    always_ff @(posedge clk)
    begin
        kind_reg[4] <= kind_reg[3];
        qhi5_reg    <= q4_reg * $signed({1'b0, kd4_reg[42:16]});
        qlo5_reg    <= q4_reg * $signed({1'b0, kd4_reg[15:0]});
        jerk5_reg   <= jerk4_reg;
        acc5_reg    <= acc4_reg;
        vel5_reg    <= vel4_reg;
        ann5_reg    <= ann4_reg;
        v0n5_reg    <= v0n4_reg;
    end

    // Stage 6: distance sum.
    always_ff @(posedge clk)
    begin
        kind_reg[5] <= kind_reg[4];
        dist6_reg   <= 66'(v0n5_reg) + 66'(ann5_reg)
                     - (66'(qhi5_reg) + round_shift(66'(qlo5_reg), 16));
        jerk6_reg   <= jerk5_reg;
        acc6_reg    <= acc5_reg;
        vel6_reg    <= vel5_reg;
    end

    // Saturation to the output ranges.
    always_comb
    begin
        sat_any = 1'b0;
        if (jerk6_reg > 34'sd2147483647)
        begin
            jerk_clip = 32'sh7FFFFFFF;
            sat_any   = 1'b1;
        end
        else if (jerk6_reg < -34'sd2147483648)
        begin
            jerk_clip = 32'sh80000000;
            sat_any   = 1'b1;
        end
        else
        begin
            jerk_clip = 32'(jerk6_reg);
        end
        if (vel6_reg > 50'sd2147483647)
        begin
            vel_clip = 32'sh7FFFFFFF;
            sat_any  = 1'b1;
        end
        else if (vel6_reg < -50'sd2147483648)
        begin
            vel_clip = 32'sh80000000;
            sat_any  = 1'b1;
        end
        else
        begin
            vel_clip = 32'(vel6_reg);
        end
        if (dist6_reg > 66'sd140737488355327)
        begin
            dist_clip = 48'sh7FFFFFFFFFFF;
            sat_any   = 1'b1;
        end
        else if (dist6_reg < -66'sd140737488355328)
        begin
            dist_clip = 48'sh800000000000;
            sat_any   = 1'b1;
        end
        else
        begin
            dist_clip = 48'(dist6_reg);
        end
    end

    // Segment start and end override the formulas.
    always_comb
    begin
        jerk_next      = '0;
        accel_next     = '0;
        distance_next  = '0;
        saturated_next = 1'b0;
        case (kind_reg[5])
            KIND_MID:
            begin
                jerk_next      = jerk_clip;
                accel_next     = acc6_reg;
                velocity_next  = vel_clip;
                distance_next  = dist_clip;
                saturated_next = sat_any;
            end
            KIND_START:
            begin
                velocity_next = cfg.v0;
            end
            default:
            begin
                velocity_next = cfg.vend;
            end
        endcase
    end

    // Stage 7: output registers.
    always_ff @(posedge clk)
    begin
        jerk_reg      <= jerk_next;
        accel_reg     <= accel_next;
        velocity_reg  <= velocity_next;
        distance_reg  <= distance_next;
        saturated_reg <= saturated_next;
    end

    assign out_valid = valid_reg[6];
    assign jerk      = jerk_reg;
    assign accel     = accel_reg;
    assign velocity  = velocity_reg;
    assign distance  = distance_reg;
    assign saturated = saturated_reg;

endmodule

// File: rtl/core/twin_sine_uturn_profile_sample.sv
// Channel        Ports                                   Transfer
// ------------   -------------------------------------   ----------------------------
// sample in      start, busy, sample_index               start high while busy low
// result out     done, jerk_out, accel_out,              done high, one cycle
//                velocity_out, distance_out, saturated
// configuration  cfg_we, cfg_index, cfg_data             cfg_we high
//
// A new sample is taken every cycle; busy is always low.
// Each result passes through QB + 1 divider stages for the phase, two table
// stages and seven arithmetic stages.
// Reset clears the configuration registers (the segment length is set to 1) and all valid bits.
// The receiver takes each result in the cycle it is shown.
module twin_sine_uturn_profile_sample
    import tsu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [N_W-1:0]       sample_index,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 done,
    output logic signed [31:0]   jerk_out,
    output logic signed [31:0]   accel_out,
    output logic signed [31:0]   velocity_out,
    output logic signed [47:0]   distance_out,
    output logic                 saturated
);

    localparam int SIDE_D = QB + 3;

    cfg_t               cfg_reg;
    logic               accept;
    kind_t              kind_in;
    logic [N_W-1:0]     n_side_reg [0:SIDE_D-1];
    kind_t              kind_side_reg [0:SIDE_D-1];
    logic               div_valid;
    logic [PH_BITS-1:0] div_phase;
    logic               lut_valid;
    logic signed [31:0] lut_sin;
    logic signed [31:0] lut_cos;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel <= '0;
            cfg_reg.jerk  <= '0;
            cfg_reg.v0    <= '0;
            cfg_reg.vend  <= '0;
            cfg_reg.len   <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PEAK_ACCEL:     cfg_reg.accel <= cfg_data[31:0];
                REG_PEAK_JERK:      cfg_reg.jerk  <= cfg_data[31:0];
                REG_START_VELOCITY: cfg_reg.v0    <= cfg_data[31:0];
                REG_END_VELOCITY:   cfg_reg.vend  <= cfg_data[31:0];
                REG_SEGMENT_LENGTH: cfg_reg.len   <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // Classify the sample: segment start, at or past the end, or inside.
    always_comb
    begin
        if (sample_index == '0)
        begin
            kind_in = KIND_START;
        end
        else if (sample_index >= cfg_reg.len)
        begin
            kind_in = KIND_END;
        end
        else
        begin
            kind_in = KIND_MID;
        end
    end

    // Index and class ride alongside the divider and table.
    always_ff @(posedge clk)
    begin
        n_side_reg[0]    <= sample_index;
        kind_side_reg[0] <= kind_in;
        for (int i = 1; i < SIDE_D; i++)
        begin
            n_side_reg[i]    <= n_side_reg[i-1];
            kind_side_reg[i] <= kind_side_reg[i-1];
        end
    end

    tsu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .n         (sample_index),
        .len       (cfg_reg.len),
        .out_valid (div_valid),
        .phase     (div_phase)
    );

    tsu_sine_lut u_lut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .phase     (div_phase),
        .out_valid (lut_valid),
        .sin_val   (lut_sin),
        .cos_val   (lut_cos)
    );

    tsu_kin u_kin (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (lut_valid),
        .sin_val   (lut_sin),
        .cos_val   (lut_cos),
        .n         (n_side_reg[SIDE_D-1]),
        .kind      (kind_side_reg[SIDE_D-1]),
        .out_valid (done),
        .jerk      (jerk_out),
        .accel     (accel_out),
        .velocity  (velocity_out),
        .distance  (distance_out),
        .saturated (saturated)
    );

endmodule
